// ----- design/mcrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrf_pkg: shared types and codes for the multi-channel ring FIFO
// Request/response structs, operation and status codes, register map.
// ----------------------------------------------------------------------------
package mcrf_pkg;

    // Default build sizes
    localparam int MAX_CHANNELS_DEF   = 32;
    localparam int MAX_DEPTH_LOG2_DEF = 8;
    localparam int WORD_WIDTH_DEF     = 32;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_DEPTH_LOG2    = 1'b1;

    // Register reset values
    localparam logic [5:0] CHANNEL_COUNT_RST = 6'd32;
    localparam logic [3:0] DEPTH_LOG2_RST    = 4'd8;

    // Operation codes
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  channel;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [8:0]  fill_count;
        logic [8:0]  free_count;
    } rsp_t;

    // Live configuration handed from the register block to the datapath
    typedef struct packed {
        logic [8:0] live_channels;  // clamped channel count
        logic [4:0] live_depth;     // clamped log2 capacity
        logic       clear;          // pulse: any register write resets pointers
    } cfg_t;

endpackage

// ----- design/mcrf_ram.sv -----
// ----------------------------------------------------------------------------
// mcrf_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mcrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mcrf_cfg.sv -----
// ----------------------------------------------------------------------------
// mcrf_cfg: APB configuration registers
// Holds channel_count and depth_log2, clamps them to the build limits and
// flags a pointer reset on every write.
// ----------------------------------------------------------------------------
module mcrf_cfg #(
    parameter int MAX_CHANNELS   = mcrf_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_DEPTH_LOG2 = mcrf_pkg::MAX_DEPTH_LOG2_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mcrf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mcrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mcrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output mcrf_pkg::cfg_t                  cfg
);
    import mcrf_pkg::*;

    logic [5:0] channel_count_reg;
    logic [3:0] depth_log2_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RST;
            depth_log2_reg    <= DEPTH_LOG2_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[5:0];
                default:           depth_log2_reg    <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channel_count_reg);
            default:           prdata = APB_DATA_W'(depth_log2_reg);
        endcase
    end

    // clamp to what the build can hold
    always_comb
    begin
        cfg.live_channels = (9'(channel_count_reg) > 9'(MAX_CHANNELS))
                          ? 9'(MAX_CHANNELS) : 9'(channel_count_reg);
        cfg.live_depth    = (5'(depth_log2_reg) > 5'(MAX_DEPTH_LOG2))
                          ? 5'(MAX_DEPTH_LOG2) : 5'(depth_log2_reg);
        cfg.clear         = wr_en;
    end

endmodule

// ----- design/multi_channel_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_channel_ring_fifo: per-channel word FIFOs sharing one memory
// Sequence: an accepted request reads its pointer word; in S_PTR the pointer
//   is written back and the word memory is accessed; in S_DATA the response
//   register is loaded. A new request may be taken while the previous one is
//   in S_DATA, as the read-modify-write of the pointer memory allows;
//   a waiting response holds off the next request.
// Reset: pointers read as zero via per-channel valid flags, cleared at once;
//   no clearing pass. The word memory is not initialized.
// ----------------------------------------------------------------------------
module multi_channel_ring_fifo #(
    parameter int MAX_CHANNELS   = mcrf_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_DEPTH_LOG2 = mcrf_pkg::MAX_DEPTH_LOG2_DEF,
    parameter int WORD_WIDTH     = mcrf_pkg::WORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mcrf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mcrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mcrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // request channel
    input  logic                            req_valid,
    output logic                            req_ready,
    input  mcrf_pkg::req_t                  req,
    // response channel
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output mcrf_pkg::rsp_t                  rsp
);
    import mcrf_pkg::*;

    // Pointers wrap modulo twice the largest capacity.
    localparam int PTR_W       = MAX_DEPTH_LOG2 + 1;
    localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STORE_DEPTH = MAX_CHANNELS << MAX_DEPTH_LOG2;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,   // waiting for a request
        S_PTR,    // pointer word back from memory: check, update, word access
        S_DATA    // word read back: build the response
    } state_t;

    cfg_t cfg;

    state_t state_reg;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;

    // request held for the duration of its processing
    req_t   req_reg;

    // partial response computed in S_PTR
    logic [1:0] status_reg;
    logic       pop_ok_reg;
    logic [8:0] fill_reg;
    logic [8:0] free_reg;

    // one flag per channel: pointer memory entry holds live data
    logic [MAX_CHANNELS-1:0] ptr_valid_reg;

    logic               req_fire;
    logic               out_free;
    logic               rsp_load;
    logic [CH_W-1:0]    rd_ch;
    logic [CH_W-1:0]    ch_idx;
    logic [2*PTR_W-1:0] ptr_rdata;
    logic [2*PTR_W-1:0] ptr_wdata;
    logic               ptr_we;
    logic [PTR_W-1:0]   wp_cur;
    logic [PTR_W-1:0]   rp_cur;
    logic [PTR_W-1:0]   wp_new;
    logic [PTR_W-1:0]   rp_new;
    logic [PTR_W-1:0]   cap;
    logic [PTR_W-1:0]   slot_mask;
    logic [PTR_W-1:0]   fill_cur;
    logic [PTR_W-1:0]   fill_new;
    logic [PTR_W-1:0]   free_new;
    logic               chan_ok;
    logic               push_ok;
    logic               pop_ok;
    logic [1:0]         status_new;
    logic               store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [STORE_AW-1:0] store_raddr;
    logic [STORE_AW-1:0] store_rd_cur;
    logic [STORE_AW-1:0] store_raddr_reg;
    logic [WORD_WIDTH-1:0] store_rdata;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    mcrf_cfg #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake. A new request may enter while the previous one is in its
    // last cycle, provided the response register can take that result.
    // Its pointer read then lands after the previous write-back, so no
    // forwarding is needed.
    // ------------------------------------------------------------------
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_DATA) && out_free);
    assign req_fire  = req_valid && req_ready;
    assign rsp_load  = (state_reg == S_DATA) && out_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Pointer memory: {write pointer, read pointer} per channel
    // ------------------------------------------------------------------
    assign rd_ch  = CH_W'(req.channel);
    assign ch_idx = CH_W'(req_reg.channel);

    mcrf_ram #(
        .WIDTH (2*PTR_W),
        .DEPTH (MAX_CHANNELS)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (ch_idx),
        .wdata (ptr_wdata),
        .raddr (rd_ch),
        .rdata (ptr_rdata)
    );

    // ------------------------------------------------------------------
    // Pointer check and update (S_PTR)
    // ------------------------------------------------------------------
    always_comb
    begin
        // never-written or cleared entries read as zero
        if (ptr_valid_reg[ch_idx])
        begin
            wp_cur = ptr_rdata[2*PTR_W-1:PTR_W];
            rp_cur = ptr_rdata[PTR_W-1:0];
        end
        else
        begin
            wp_cur = '0;
            rp_cur = '0;
        end

        cap       = PTR_W'(1) << cfg.live_depth;
        slot_mask = cap - PTR_W'(1);
        fill_cur  = wp_cur - rp_cur;
        chan_ok   = 9'(req_reg.channel) < cfg.live_channels;
        push_ok   = (req_reg.kind == KIND_PUSH) && (fill_cur < cap);
        pop_ok    = (req_reg.kind == KIND_POP) && (fill_cur != '0);

        wp_new     = wp_cur;
        rp_new     = rp_cur;
        status_new = ST_DONE;
        case (req_reg.kind)
            KIND_PUSH:
            begin
                if (push_ok)
                begin
                    wp_new = wp_cur + PTR_W'(1);
                end
                else
                begin
                    status_new = ST_FULL;
                end
            end
            KIND_POP:
            begin
                if (pop_ok)
                begin
                    rp_new = rp_cur + PTR_W'(1);
                end
                else
                begin
                    status_new = ST_EMPTY;
                end
            end
            KIND_CLEAR:
            begin
                wp_new = '0;
                rp_new = '0;
            end
            default:
            begin
                // query: counts only
            end
        endcase

        fill_new = wp_new - rp_new;
        free_new = (fill_new >= cap) ? '0 : (cap - fill_new);

        ptr_wdata = {wp_new, rp_new};
        ptr_we    = (state_reg == S_PTR) && chan_ok
                 && (push_ok || pop_ok || (req_reg.kind == KIND_CLEAR));
    end

    // ------------------------------------------------------------------
    // Word memory: channel c owns the slot range c * 2^MAX_DEPTH_LOG2 on
    // ------------------------------------------------------------------
    assign store_we     = (state_reg == S_PTR) && chan_ok && push_ok;
    assign store_waddr  = STORE_AW'((32'(ch_idx) << MAX_DEPTH_LOG2) | 32'(wp_cur & slot_mask));
    assign store_rd_cur = STORE_AW'((32'(ch_idx) << MAX_DEPTH_LOG2) | 32'(rp_cur & slot_mask));
    // pop address held while the response waits, so the read word stays put
    assign store_raddr  = (state_reg == S_PTR) ? store_rd_cur : store_raddr_reg;

    mcrf_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_word_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (WORD_WIDTH'(req_reg.write_data)),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Pointer valid flags: set on write-back, all cleared on a config write
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_valid_reg <= '0;
        end
        else if (cfg.clear)
        begin
            ptr_valid_reg <= '0;
        end
        else if (ptr_we)
        begin
            ptr_valid_reg[ch_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request and partial-result holding registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (state_reg == S_PTR)
        begin
            store_raddr_reg <= store_rd_cur;
            if (chan_ok)
            begin
                status_reg <= status_new;
                pop_ok_reg <= pop_ok;
                fill_reg   <= 9'(fill_new);
                free_reg   <= 9'(free_new);
            end
            else
            begin
                status_reg <= ST_INVALID;
                pop_ok_reg <= 1'b0;
                fill_reg   <= '0;
                free_reg   <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_PTR;
                    end
                end
                S_PTR:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    if (out_free)
                    begin
                        rsp_reg.status     <= status_reg;
                        rsp_reg.read_data  <= pop_ok_reg ? 32'(store_rdata) : '0;
                        rsp_reg.fill_count <= fill_reg;
                        rsp_reg.free_count <= free_reg;
                        state_reg          <= req_fire ? S_PTR : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
